@@ design/tcon_pkg.sv @@
// tcon_pkg: shared constants, operation codes and types for the text console
// no dependencies; used by the interfaces and every module of the console
package tcon_pkg;

  // default screen geometry and command queue depth
  localparam int COLS_DEFAULT        = 80;
  localparam int ROWS_DEFAULT        = 25;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // fixed field widths of the channel words
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int FCOL_W = 7;
  localparam int FROW_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE    = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 2'd3;

  // blank character used by clear and scroll
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // classified command as held in the queue (col and row already clamped)
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] attribute;
    logic [FCOL_W-1:0] col;
    logic [FROW_W-1:0] row;
  } cmd_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

@@ design/tcon_ifs.sv @@
// tcon_cmd_if and tcon_rsp_if: valid/ready channels of the text console
// depends on tcon_pkg for field widths
interface tcon_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tcon_pkg::OP_W-1:0]    operation;
  logic [tcon_pkg::BYTE_W-1:0]  char_code;
  logic [tcon_pkg::BYTE_W-1:0]  attribute;
  logic [tcon_pkg::FCOL_W-1:0]  col;
  logic [tcon_pkg::FROW_W-1:0]  row;

  modport source (output valid, operation, char_code, attribute, col, row, input ready);
  modport sink   (input valid, operation, char_code, attribute, col, row, output ready);
endinterface

interface tcon_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcon_pkg::FCOL_W-1:0]  cursor_col;
  logic [tcon_pkg::FROW_W-1:0]  cursor_row;
  logic [tcon_pkg::BYTE_W-1:0]  read_char;
  logic [tcon_pkg::BYTE_W-1:0]  read_attr;

  modport source (output valid, cursor_col, cursor_row, read_char, read_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, read_char, read_attr, output ready);
endinterface

@@ design/tcon_front.sv @@
// tcon_front: accepts command words, clamps col/row and holds one classified command
// depends on tcon_pkg and tcon_cmd_if; feeds tcon_queue
module tcon_front #(
  parameter int COLS = tcon_pkg::COLS_DEFAULT,
  parameter int ROWS = tcon_pkg::ROWS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  tcon_cmd_if.sink                cmd,
  input  logic                    clearing,
  input  tcon_pkg::queue_status_t q_status,
  output logic                    push,
  output tcon_pkg::cmd_t          push_cmd
);

  localparam int COL_MAX = COLS - 1;
  localparam int ROW_MAX = ROWS - 1;

  logic           stg_valid;
  tcon_pkg::cmd_t stg;
  tcon_pkg::cmd_t classified;

  // clamp position to the screen
  always_comb begin
    classified.operation = cmd.operation;
    classified.char_code = cmd.char_code;
    classified.attribute = cmd.attribute;
    classified.col       = cmd.col;
    classified.row       = cmd.row;
    if (9'(cmd.col) > 9'(COL_MAX)) begin
      classified.col = tcon_pkg::FCOL_W'(COL_MAX);
    end
    if (8'(cmd.row) > 8'(ROW_MAX)) begin
      classified.row = tcon_pkg::FROW_W'(ROW_MAX);
    end
  end

  // handshake: hand the staged word on when the queue has room
  assign push      = stg_valid && !q_status.full;
  assign push_cmd  = stg;
  assign cmd.ready = !clearing && (!stg_valid || push);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  // staged payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stg <= classified;
    end
  end

endmodule

@@ design/tcon_queue.sv @@
// tcon_queue: short command queue between front and back of the console
// depends on tcon_pkg
module tcon_queue #(
  parameter int DEPTH = tcon_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  tcon_pkg::cmd_t          push_data,
  input  logic                    pop,
  output tcon_pkg::cmd_t          pop_data,
  output tcon_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcon_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.empty = (count == CNT_W'(0));
  assign status.full  = (count == CNT_W'(DEPTH));
  assign pop_data     = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/tcon_back.sv @@
// tcon_back: screen store, cursor and sequencer for write, read, scroll and clear
// depends on tcon_pkg and tcon_rsp_if; takes commands from tcon_queue
module tcon_back #(
  parameter int COLS = tcon_pkg::COLS_DEFAULT,
  parameter int ROWS = tcon_pkg::ROWS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tcon_pkg::queue_status_t q_status,
  input  tcon_pkg::cmd_t          head,
  output logic                    pop,
  output logic                    clearing,
  tcon_rsp_if.source              rsp
);

  localparam int CELLS  = COLS * ROWS;
  localparam int POS_W  = $clog2(CELLS);
  localparam int CCOL_W = $clog2(COLS);
  localparam int CROW_W = $clog2(ROWS);
  localparam logic [POS_W-1:0] LAST_BASE = POS_W'((ROWS - 1) * COLS);
  localparam logic [POS_W-1:0] LAST_CELL = POS_W'(CELLS - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_SCROLL = 2'd3;

  logic [1:0]              state;
  logic [CCOL_W-1:0]       cur_col;
  logic [CROW_W-1:0]       cur_row;
  logic [POS_W-1:0]        cur_base;
  logic [CCOL_W-1:0]       cur_col_next;
  logic [CROW_W-1:0]       cur_row_next;
  logic [POS_W-1:0]        cur_base_next;
  logic                    go_scroll;
  logic [POS_W-1:0]        walk_idx;
  logic                    walking;
  logic                    wr_pend;
  logic [POS_W-1:0]        wr_addr;
  logic [15:0]             rdata;
  logic [15:0]             mem [CELLS];
  logic                    mem_we;
  logic [POS_W-1:0]        mem_waddr;
  logic [15:0]             mem_wdata;
  logic                    mem_re;
  logic [POS_W-1:0]        mem_raddr;
  logic [POS_W-1:0]        cur_addr;
  logic [POS_W-1:0]        row_base;
  logic [POS_W-1:0]        head_addr;
  logic [POS_W-1:0]        scroll_src;
  logic                    at_line_end;
  logic                    on_last_row;
  logic                    slot_free;
  logic                    result_load;
  logic                    out_valid;
  logic [tcon_pkg::FCOL_W-1:0] out_col;
  logic [tcon_pkg::FROW_W-1:0] out_row;
  logic [tcon_pkg::BYTE_W-1:0] out_char;
  logic [tcon_pkg::BYTE_W-1:0] out_attr;

  assign clearing  = (state == S_CLEAR);
  assign slot_free = !out_valid || rsp.ready;
  assign pop       = (state == S_IDLE) && !q_status.empty && slot_free;

  // address arithmetic
  assign cur_addr    = cur_base + POS_W'(cur_col);
  assign row_base    = POS_W'(head.row) * POS_W'(COLS);
  assign head_addr   = row_base + POS_W'(head.col);
  assign scroll_src  = (walk_idx < LAST_BASE) ? walk_idx + POS_W'(COLS) : walk_idx;
  assign at_line_end = (cur_col == CCOL_W'(COLS - 1));
  assign on_last_row = (cur_row == CROW_W'(ROWS - 1));

  // next cursor for the command at the queue head
  always_comb begin
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    cur_base_next = cur_base;
    go_scroll     = 1'b0;
    case (head.operation)
      tcon_pkg::OP_PUT_CHAR, tcon_pkg::OP_NEWLINE: begin
        if (head.operation == tcon_pkg::OP_PUT_CHAR && !at_line_end) begin
          cur_col_next = cur_col + CCOL_W'(1);
        end else begin
          cur_col_next = '0;
          if (on_last_row) begin
            go_scroll = 1'b1;
          end else begin
            cur_row_next  = cur_row + CROW_W'(1);
            cur_base_next = cur_base + POS_W'(COLS);
          end
        end
      end
      tcon_pkg::OP_SET_CURSOR: begin
        cur_col_next  = CCOL_W'(head.col);
        cur_row_next  = CROW_W'(head.row);
        cur_base_next = row_base;
      end
      default: ;
    endcase
  end

  // result register loads at the end of every command
  assign result_load = (pop && (head.operation != tcon_pkg::OP_READ_CELL) && !go_scroll)
                    || (state == S_READ)
                    || ((state == S_SCROLL) && wr_pend && (wr_addr == LAST_CELL));

  // screen store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {head.attribute, head.char_code};
    mem_re    = 1'b0;
    mem_raddr = head_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = walk_idx;
        mem_wdata = {8'h00, tcon_pkg::SPACE_CHAR};
      end
      S_IDLE: begin
        mem_we = pop && (head.operation == tcon_pkg::OP_PUT_CHAR);
        mem_re = pop && (head.operation == tcon_pkg::OP_READ_CELL);
      end
      S_SCROLL: begin
        mem_re    = walking;
        mem_raddr = scroll_src;
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = (wr_addr >= LAST_BASE) ? {rdata[15:8], tcon_pkg::SPACE_CHAR} : rdata;
      end
      default: ;
    endcase
  end

  // screen store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      walk_idx  <= '0;
      walking   <= 1'b0;
      wr_pend   <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // write back in the cycle after the read issue
      wr_pend <= (state == S_SCROLL) && walking;
      case (state)
        S_CLEAR: begin
          if (walk_idx == LAST_CELL) begin
            walk_idx <= '0;
            state    <= S_IDLE;
          end else begin
            walk_idx <= walk_idx + POS_W'(1);
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur_col  <= cur_col_next;
            cur_row  <= cur_row_next;
            cur_base <= cur_base_next;
            if (head.operation == tcon_pkg::OP_READ_CELL) begin
              state <= S_READ;
            end else if (go_scroll) begin
              state    <= S_SCROLL;
              walking  <= 1'b1;
              walk_idx <= '0;
            end else begin
              out_col   <= tcon_pkg::FCOL_W'(cur_col_next);
              out_row   <= tcon_pkg::FROW_W'(cur_row_next);
              out_char  <= '0;
              out_attr  <= '0;
            end
          end
        end
        S_READ: begin
          out_col   <= tcon_pkg::FCOL_W'(cur_col);
          out_row   <= tcon_pkg::FROW_W'(cur_row);
          out_char  <= rdata[7:0];
          out_attr  <= rdata[15:8];
          state     <= S_IDLE;
        end
        S_SCROLL: begin
          if (walking) begin
            wr_addr  <= walk_idx;
            walk_idx <= walk_idx + POS_W'(1);
            if (walk_idx == LAST_CELL) begin
              walking <= 1'b0;
            end
          end
          if (wr_pend && wr_addr == LAST_CELL) begin
            out_col   <= tcon_pkg::FCOL_W'(cur_col);
            out_row   <= tcon_pkg::FROW_W'(cur_row);
            out_char  <= '0;
            out_attr  <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cursor_col = out_col;
  assign rsp.cursor_row = out_row;
  assign rsp.read_char  = out_char;
  assign rsp.read_attr  = out_attr;

endmodule

@@ design/text_console_cursor_scroll.sv @@
// text_console_cursor_scroll: top level of the text console engine
// depends on tcon_pkg, tcon_ifs, tcon_front, tcon_queue and tcon_back
//
//   channel  dir  word                                            taken when
//   cmd      in   operation, char_code, attribute, col, row       valid && ready
//   rsp      out  cursor_col, cursor_row, read_char, read_attr    valid && ready
//
// put char, newline and set cursor pass from intake through the front stage, the queue
// and the back update into the result register that raises rsp.valid; read cell also
// passes through the store read. a scroll walks the whole store through its single port
// pair before it raises rsp.valid, while the queue holds later commands. after reset a
// clearing pass blanks every cell of the store and cmd stays not ready. a stalled rsp
// holds the back; the front stage and queue keep taking words until they fill.
module text_console_cursor_scroll #(
  parameter int COLS        = tcon_pkg::COLS_DEFAULT,
  parameter int ROWS        = tcon_pkg::ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = tcon_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tcon_cmd_if.sink   cmd,
  tcon_rsp_if.source rsp
);

  logic                    clearing;
  logic                    push;
  logic                    pop;
  tcon_pkg::cmd_t          push_cmd;
  tcon_pkg::cmd_t          head;
  tcon_pkg::queue_status_t q_status;

  // intake and classification
  tcon_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .clearing (clearing),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  tcon_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (head),
    .status    (q_status)
  );

  // execution and screen store
  tcon_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  // checks
  a_no_intake_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd.ready)
    else $error("command word taken during clearing pass");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rsp.valid)
    else $error("result offered during clearing pass");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("back took a command from an empty queue");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (int'(rsp.cursor_col) < COLS) && (int'(rsp.cursor_row) < ROWS))
    else $error("cursor reported off screen");

endmodule

@@ verif/tb_text_console_cursor_scroll.sv @@
// tb_text_console_cursor_scroll: self-checking bench for the text console engine
// depends on tcon_pkg, tcon_ifs and text_console_cursor_scroll; drives cmd words with gaps,
// stalls rsp at random and checks every result word against the directed table or an in-bench screen predictor
module tb_text_console_cursor_scroll;

  localparam int SCR_COLS      = tcon_pkg::COLS_DEFAULT;
  localparam int SCR_ROWS      = tcon_pkg::ROWS_DEFAULT;
  localparam int CELLS         = SCR_COLS * SCR_ROWS;
  localparam int RANDOM_WORDS  = 950;
  localparam int SCROLL_BUDGET = 30;
  localparam int TAIL_CYCLES   = 40;
  localparam int TIMEOUT_UNITS = 4_000_000;

  typedef struct packed {
    logic [tcon_pkg::FCOL_W-1:0] cursor_col;
    logic [tcon_pkg::FROW_W-1:0] cursor_row;
    logic [tcon_pkg::BYTE_W-1:0] read_char;
    logic [tcon_pkg::BYTE_W-1:0] read_attr;
  } cursor_report_t;

  typedef struct {
    tcon_pkg::cmd_t word;
    bit             typed;
    cursor_report_t want;
  } script_row_t;

  logic clk;
  logic rst;

  tcon_cmd_if cmd_ch ();
  tcon_rsp_if rsp_ch ();

  text_console_cursor_scroll u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // predicted screen contents and cursor
  logic [15:0]    screen_model [CELLS];
  int unsigned    cursor_lin;
  int unsigned    recent_cells [16];
  int unsigned    recent_wr;

  cursor_report_t pending_reports [$];
  script_row_t    script [$];
  int unsigned    mismatches;
  int unsigned    scrolls_issued;
  bit             src_idle_on = 1'b1;
  bit             sink_idle_on = 1'b1;
  int unsigned    sink_stall_left;

  // clock, period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // column and row limited to the screen, as a linear cell index
  function automatic int unsigned clamped_cell(logic [tcon_pkg::FCOL_W-1:0] c,
                                               logic [tcon_pkg::FROW_W-1:0] r);
    int unsigned cc;
    int unsigned rr;
    cc = (int'(c) > SCR_COLS - 1) ? SCR_COLS - 1 : int'(c);
    rr = (int'(r) > SCR_ROWS - 1) ? SCR_ROWS - 1 : int'(r);
    return rr * SCR_COLS + cc;
  endfunction

  // rows move up one, bottom row blanked but keeps its attributes
  function automatic void scroll_model();
    for (int i = 0; i < (SCR_ROWS - 1) * SCR_COLS; i++)
      screen_model[i] = screen_model[i + SCR_COLS];
    for (int i = (SCR_ROWS - 1) * SCR_COLS; i < CELLS; i++)
      screen_model[i][7:0] = tcon_pkg::SPACE_CHAR;
    cursor_lin = (SCR_ROWS - 1) * SCR_COLS;
  endfunction

  function automatic bit would_scroll(tcon_pkg::cmd_t w);
    case (w.operation)
      tcon_pkg::OP_PUT_CHAR: return (cursor_lin + 1 >= CELLS);
      tcon_pkg::OP_NEWLINE:  return (cursor_lin - cursor_lin % SCR_COLS + SCR_COLS >= CELLS);
      default:               return 1'b0;
    endcase
  endfunction

  // applies one command word to the screen and cursor, returns the result word
  function automatic cursor_report_t apply_console_cmd(tcon_pkg::cmd_t w);
    cursor_report_t rep;
    int unsigned    nxt;
    int unsigned    addr;
    rep = '0;
    if (cursor_lin >= CELLS)
      cursor_lin = 0;
    case (w.operation)
      tcon_pkg::OP_PUT_CHAR: begin
        screen_model[cursor_lin] = {w.attribute, w.char_code};
        recent_cells[recent_wr] = cursor_lin;
        recent_wr = (recent_wr + 1) % 16;
        cursor_lin++;
        if (cursor_lin >= CELLS)
          scroll_model();
      end
      tcon_pkg::OP_NEWLINE: begin
        nxt = cursor_lin - cursor_lin % SCR_COLS + SCR_COLS;
        if (nxt >= CELLS)
          scroll_model();
        else
          cursor_lin = nxt;
      end
      tcon_pkg::OP_SET_CURSOR: begin
        cursor_lin = clamped_cell(w.col, w.row);
      end
      default: begin
        addr = clamped_cell(w.col, w.row);
        rep.read_char = screen_model[addr][7:0];
        rep.read_attr = screen_model[addr][15:8];
      end
    endcase
    rep.cursor_col = tcon_pkg::FCOL_W'(cursor_lin % SCR_COLS);
    rep.cursor_row = tcon_pkg::FROW_W'(cursor_lin / SCR_COLS);
    return rep;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10)
      return 0;
    else if (r < 19)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // random command word; scrolls are rationed since each one walks the whole store
  function automatic tcon_pkg::cmd_t random_console_cmd();
    tcon_pkg::cmd_t w;
    int unsigned    pick;
    int unsigned    pick_cell;
    w.char_code = tcon_pkg::BYTE_W'($urandom_range(0, 255));
    w.attribute = tcon_pkg::BYTE_W'($urandom_range(0, 255));
    w.col       = tcon_pkg::FCOL_W'($urandom_range(0, 127));
    w.row       = tcon_pkg::FROW_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.operation = tcon_pkg::OP_PUT_CHAR;
    end else if (pick < 55) begin
      w.operation = tcon_pkg::OP_NEWLINE;
    end else if (pick < 75) begin
      w.operation = tcon_pkg::OP_SET_CURSOR;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        // near the last cell, so put char soon scrolls
        w.row = tcon_pkg::FROW_W'(SCR_ROWS - 1);
        w.col = tcon_pkg::FCOL_W'($urandom_range(SCR_COLS - 8, SCR_COLS - 1));
      end else if (pick < 16) begin
        w.col = tcon_pkg::FCOL_W'($urandom_range(0, SCR_COLS - 1));
        w.row = tcon_pkg::FROW_W'($urandom_range(0, SCR_ROWS - 1));
      end
    end else begin
      w.operation = tcon_pkg::OP_READ_CELL;
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        // a cell written lately
        pick_cell = recent_cells[$urandom_range(0, 15)];
        w.col = tcon_pkg::FCOL_W'(pick_cell % SCR_COLS);
        w.row = tcon_pkg::FROW_W'(pick_cell / SCR_COLS);
      end else if (pick == 2) begin
        w.col = tcon_pkg::FCOL_W'($urandom_range(0, SCR_COLS - 1));
        w.row = tcon_pkg::FROW_W'($urandom_range(0, SCR_ROWS - 1));
      end
    end
    if (would_scroll(w)) begin
      if (scrolls_issued >= SCROLL_BUDGET || $urandom_range(0, 2) != 0)
        w.operation = tcon_pkg::OP_READ_CELL;
      else
        scrolls_issued++;
    end
    return w;
  endfunction

  task automatic add_row(input logic [tcon_pkg::OP_W-1:0] op, input int ch, input int at,
                         input int c, input int r, input bit typed,
                         input int ecol, input int erow, input int echar, input int eattr);
    script_row_t s;
    s.word.operation = op;
    s.word.char_code = tcon_pkg::BYTE_W'(ch);
    s.word.attribute = tcon_pkg::BYTE_W'(at);
    s.word.col       = tcon_pkg::FCOL_W'(c);
    s.word.row       = tcon_pkg::FROW_W'(r);
    s.typed          = typed;
    s.want.cursor_col = tcon_pkg::FCOL_W'(ecol);
    s.want.cursor_row = tcon_pkg::FROW_W'(erow);
    s.want.read_char  = tcon_pkg::BYTE_W'(echar);
    s.want.read_attr  = tcon_pkg::BYTE_W'(eattr);
    script.push_back(s);
  endtask

  // drives one cmd word, predicts its result once it is taken
  task automatic send_console_cmd(input tcon_pkg::cmd_t w, input bit typed,
                                  input cursor_report_t want);
    int unsigned    gap;
    cursor_report_t predicted;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= w.operation;
    cmd_ch.char_code <= w.char_code;
    cmd_ch.attribute <= w.attribute;
    cmd_ch.col       <= w.col;
    cmd_ch.row       <= w.row;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    predicted = apply_console_cmd(w);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // stimulus
  initial begin : stimulus
    tcon_pkg::cmd_t w;
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= tcon_pkg::OP_PUT_CHAR;
    cmd_ch.char_code <= '0;
    cmd_ch.attribute <= '0;
    cmd_ch.col       <= '0;
    cmd_ch.row       <= '0;
    for (int i = 0; i < CELLS; i++)
      screen_model[i] = {8'h00, tcon_pkg::SPACE_CHAR};
    cursor_lin = 0;

    //       op                       ch     at     col  row typed col row char   attr
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 0,   0,   1,  0,  0,  8'h20, 8'h00);
    add_row(tcon_pkg::OP_READ_CELL,  8'hFF, 8'hFF, 127, 31,  1,  0,  0,  8'h20, 8'h00);
    add_row(tcon_pkg::OP_PUT_CHAR,   8'h41, 8'h07, 0,   0,   1,  1,  0,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_PUT_CHAR,   8'h00, 8'h00, 0,   0,   1,  2,  0,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_PUT_CHAR,   8'hFF, 8'hFF, 0,   0,   1,  3,  0,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 0,   0,   1,  3,  0,  8'h41, 8'h07);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 2,   0,   1,  3,  0,  8'hFF, 8'hFF);
    add_row(tcon_pkg::OP_NEWLINE,    8'h00, 8'h00, 0,   0,   1,  0,  1,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 79,  0,   1,  79, 0,  8'h00, 8'h00);
    // put char at the end of a row wraps to the next
    add_row(tcon_pkg::OP_PUT_CHAR,   8'h55, 8'hAA, 0,   0,   1,  0,  1,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 127, 31,  1,  79, 24, 8'h00, 8'h00);
    // put char in the last cell scrolls
    add_row(tcon_pkg::OP_PUT_CHAR,   8'h5A, 8'hA5, 0,   0,   1,  0,  24, 8'h00, 8'h00);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 79,  23,  1,  0,  24, 8'h5A, 8'hA5);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 79,  24,  1,  0,  24, 8'h20, 8'hA5);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 0,   0,   1,  0,  24, 8'h20, 8'h00);
    // newline on the last row scrolls
    add_row(tcon_pkg::OP_NEWLINE,    8'h00, 8'h00, 0,   0,   1,  0,  24, 8'h00, 8'h00);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 79,  23,  0,  0,  0,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_READ_CELL,  8'h00, 8'h00, 79,  22,  0,  0,  0,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 40,  12,  1,  40, 12, 8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 0,   31,  1,  0,  24, 8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 100, 5,   1,  79, 5,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_NEWLINE,    8'h00, 8'h00, 0,   0,   1,  0,  6,  8'h00, 8'h00);
    // unused fields set high must be ignored
    add_row(tcon_pkg::OP_PUT_CHAR,   8'h7E, 8'h1F, 127, 31,  1,  1,  6,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_NEWLINE,    8'hFF, 8'hFF, 127, 31,  1,  0,  7,  8'h00, 8'h00);
    add_row(tcon_pkg::OP_SET_CURSOR, 8'hFF, 8'hFF, 3,   3,   1,  3,  3,  8'h00, 8'h00);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (script[i])
      send_console_cmd(script[i].word, script[i].typed, script[i].want);

    // random words, with idle-free stretches and an occasional full drain
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0)
        src_idle_on = ($urandom_range(0, 3) != 0);
      if (n % 160 == 159) begin
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
      end
      w = random_console_cmd();
      send_console_cmd(w, 1'b0, '0);
    end

    // drain and settle
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // rsp back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0)
        sink_idle_on = !sink_idle_on;
      if (sink_stall_left != 0) begin
        sink_stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 7) == 0)
          sink_stall_left = pick_gap();
      end
    end
  end

  // result word checker
  always @(posedge clk) begin : check_results
    cursor_report_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected word expected none got col %0d row %0d char %0h attr %0h",
                 $time, rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.read_char,
                 rsp_ch.read_attr);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_col", 8'(want.cursor_col), 8'(rsp_ch.cursor_col));
        check_field("cursor_row", 8'(want.cursor_row), 8'(rsp_ch.cursor_row));
        check_field("read_char", want.read_char, rsp_ch.read_char);
        check_field("read_attr", want.read_attr, rsp_ch.read_attr);
      end
    end
  end

  // hang guard
  initial begin
    #(TIMEOUT_UNITS);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ text_console_cursor_scroll.f @@
design/tcon_pkg.sv
design/tcon_ifs.sv
design/tcon_front.sv
design/tcon_queue.sv
design/tcon_back.sv
design/text_console_cursor_scroll.sv
verif/tb_text_console_cursor_scroll.sv
